### design/cfs_pkg.sv
// ----------------------------------------------------------------------------
// Cuckoo fingerprint set package
// Outcome codes, the command type and the queue record shared by the modules.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam int unsigned TAG_W     = 32;
  localparam int unsigned FP_W      = 64;
  localparam int unsigned OUTCOME_W = 3;
  localparam int unsigned COUNT_W   = 13;
  localparam int unsigned STASH_N   = 2;

  typedef enum logic [OUTCOME_W-1:0] {
    OC_MISS    = 3'd0,
    OC_HIT     = 3'd1,
    OC_PRESENT = 3'd2,
    OC_PLACED  = 3'd3,
    OC_STASHED = 3'd4,
    OC_DROPPED = 3'd5
  } outcome_t;

  // Command recorded by the front end and handed to the back end.
  typedef struct packed {
    logic               insert;
    logic [TAG_W-1:0]   tag;
    logic [TAG_W-1:0]   lo;
  } cmd_t;

  // Tag is 1 + fp mod (2^32 - 1), using an end-around carry.
  function automatic logic [TAG_W-1:0] make_tag(input logic [FP_W-1:0] fp);
    logic [TAG_W-1:0] lo;
    logic [TAG_W-1:0] hi;
    logic [TAG_W:0]   sum;
    lo = fp[TAG_W-1:0] + 32'd1;
    hi = fp[FP_W-1:TAG_W];
    if (lo == '0) begin
      lo = 32'd1;
    end
    sum = {1'b0, lo} + {1'b0, hi};
    return sum[TAG_W-1:0] + {31'd0, sum[TAG_W]};
  endfunction

endpackage

### design/cfs_front.sv
// ----------------------------------------------------------------------------
// Cuckoo fingerprint set front end
// Accepts commands, derives the tag and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module cfs_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [cfs_pkg::FP_W-1:0] in_data,
  input  logic                   in_cmd,
  output logic                   q_valid,
  input  logic                   q_ready,
  output cfs_pkg::cmd_t          q_cmd
);
  import cfs_pkg::*;

  cmd_t       ent_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, wr_r;
  logic       push, pop;
  cmd_t       new_cmd;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_cmd     = ent_r[rd_r];

  always_comb begin
    new_cmd.insert = in_cmd;
    new_cmd.tag    = make_tag(in_data);
    new_cmd.lo     = in_data[TAG_W-1:0];
    cnt_nxt        = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (pop) begin
        rd_r <= ~rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= new_cmd;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !in_tready) else $error("full queue accepts");
  a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !q_valid) else $error("empty queue offers");

endmodule

### design/cfs_back.sv
// ----------------------------------------------------------------------------
// Cuckoo fingerprint set back end
// Bucket memory, stash and the lookup, fill and kick sequencer.
// ----------------------------------------------------------------------------
module cfs_back #(
  parameter int unsigned LOG_BUCKETS  = 10,
  parameter int unsigned BUCKET_SLOTS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  cfs_pkg::cmd_t               q_cmd,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [cfs_pkg::OUTCOME_W-1:0] out_outcome,
  output logic [cfs_pkg::COUNT_W-1:0] out_occupancy
);
  import cfs_pkg::*;

  localparam int unsigned NB      = 1 << LOG_BUCKETS;
  localparam int unsigned ROW_W   = TAG_W * BUCKET_SLOTS;
  localparam int unsigned KICKS   = 2 * LOG_BUCKETS + 1;
  localparam int unsigned KICK_W  = $clog2(KICKS + 1);
  localparam int unsigned SLOT_W  = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int unsigned CNT_MAX = (1 << COUNT_W) - 1;
  // The tag count reaches at most NB * BUCKET_SLOTS + 2.
  localparam int unsigned CTR_W   = (LOG_BUCKETS + 3 > COUNT_W) ? LOG_BUCKETS + 3
                                                                : COUNT_W + 1;

  typedef logic [LOG_BUCKETS-1:0] bidx_t;

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_RD1   = 10'b0000000100,
    ST_RD2   = 10'b0000001000,
    ST_CHK   = 10'b0000010000,
    ST_KRD   = 10'b0000100000,
    ST_KWAIT = 10'b0001000000,
    ST_KCHK  = 10'b0010000000,
    ST_STASH = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  state_t             st_r, st_nxt;
  logic [ROW_W-1:0]   mem [NB];
  logic [ROW_W-1:0]   rd_q;
  logic               rd_en, wr_en;
  bidx_t              rd_a, wr_a;
  logic [ROW_W-1:0]   wr_d;

  bidx_t              clr_r;
  cmd_t               cmd_r;
  bidx_t              i1_r, i2_r;
  logic [ROW_W-1:0]   row1_r;
  logic [TAG_W-1:0]   ktag_r;
  bidx_t              kidx_r;
  logic [KICK_W-1:0]  kcnt_r;
  logic [TAG_W-1:0]   stag_r [STASH_N];
  bidx_t              sbkt_r [STASH_N];
  logic [1:0]         sfill_r;
  logic [CTR_W-1:0]   count_r;
  logic               ovalid_r;
  outcome_t           oc_r;

  // Single-port-write, single-read bucket memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_a] <= wr_d;
    end
    if (rd_en) begin
      rd_q <= mem[rd_a];
    end
  end

  function automatic logic row_has(input logic [ROW_W-1:0] r, input logic [TAG_W-1:0] t);
    logic h;
    h = 1'b0;
    for (int s = 0; s < BUCKET_SLOTS; s++) begin
      if (r[s*TAG_W +: TAG_W] == t) begin
        h = 1'b1;
      end
    end
    return h;
  endfunction

  function automatic logic row_empty(input logic [ROW_W-1:0] r, output logic [SLOT_W-1:0] sl);
    logic f;
    f  = 1'b0;
    sl = '0;
    for (int s = BUCKET_SLOTS - 1; s >= 0; s--) begin
      if (r[s*TAG_W +: TAG_W] == '0) begin
        f  = 1'b1;
        sl = SLOT_W'(s);
      end
    end
    return f;
  endfunction

  // Index derivation of a new command.
  bidx_t ci1, ci2, ca, cb;
  always_comb begin
    ca = q_cmd.lo[LOG_BUCKETS-1:0];
    cb = ca ^ q_cmd.tag[LOG_BUCKETS-1:0];
    ci1 = ca;
    ci2 = cb;
    if (sfill_r != 2'd0 && ca > cb) begin
      ci1 = cb;
      ci2 = ca;
    end
  end

  // Combinational decisions taken in the check states.
  logic              stash_hit, hit1, hit2, e1, e2;
  logic [SLOT_W-1:0] s1, s2;
  logic              use1;
  logic [ROW_W-1:0]  fill_row, shift_row;
  logic [TAG_W-1:0]  kout;
  bidx_t             knext;
  logic              ke;
  logic [SLOT_W-1:0] ks;
  bidx_t             va, vb;

  always_comb begin
    stash_hit = 1'b0;
    for (int k = 0; k < STASH_N; k++) begin
      if (sfill_r > 2'(k) && stag_r[k] == cmd_r.tag &&
          (sbkt_r[k] == i1_r || sbkt_r[k] == i2_r)) begin
        stash_hit = 1'b1;
      end
    end
    hit1 = row_has(row1_r, cmd_r.tag);
    hit2 = row_has(rd_q, cmd_r.tag);
    e1   = row_empty(row1_r, s1);
    e2   = row_empty(rd_q, s2);
    // Slot order b1[0], b2[0], b1[1], ...: first bucket wins ties.
    use1 = e1 && (!e2 || s1 <= s2);
    fill_row = use1 ? row1_r : rd_q;
    fill_row[(use1 ? s1 : s2)*TAG_W +: TAG_W] = cmd_r.tag;
    // Kick: evict slot 0, shift down, new tag into the last slot.
    kout      = rd_q[TAG_W-1:0];
    shift_row = {ktag_r, rd_q[ROW_W-1:TAG_W]};
    knext     = kidx_r ^ kout[LOG_BUCKETS-1:0];
    ke        = row_empty(rd_q, ks);
    va        = kidx_r;
    vb        = kidx_r ^ ktag_r[LOG_BUCKETS-1:0];
  end

  logic [ROW_W-1:0] kfill_row;
  always_comb begin
    kfill_row = rd_q;
    kfill_row[ks*TAG_W +: TAG_W] = ktag_r;
  end

  always_comb begin
    st_nxt = st_r;
    rd_en  = 1'b0;
    rd_a   = ci1;
    wr_en  = 1'b0;
    wr_a   = clr_r;
    wr_d   = '0;
    q_ready = 1'b0;
    case (st_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (clr_r == bidx_t'(NB - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        q_ready = 1'b1;
        rd_en   = 1'b1;
        if (q_valid) begin
          st_nxt = ST_RD1;
        end
      end
      ST_RD1: begin
        rd_en  = 1'b1;
        rd_a   = i2_r;
        st_nxt = ST_RD2;
      end
      ST_RD2: begin
        st_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (stash_hit || hit1 || hit2 || !cmd_r.insert) begin
          st_nxt = ST_OUT;
        end else if (e1 || e2) begin
          wr_en  = 1'b1;
          wr_a   = use1 ? i1_r : i2_r;
          wr_d   = fill_row;
          st_nxt = ST_OUT;
        end else begin
          rd_en  = 1'b1;
          rd_a   = i1_r;
          st_nxt = ST_KWAIT;
        end
      end
      ST_KWAIT: begin
        // Evict from the bucket just read, then read the alternate bucket.
        wr_en  = 1'b1;
        wr_a   = kidx_r;
        wr_d   = shift_row;
        rd_en  = 1'b1;
        rd_a   = knext;
        st_nxt = ST_KRD;
      end
      ST_KRD: begin
        st_nxt = ST_KCHK;
      end
      ST_KCHK: begin
        if (ke) begin
          wr_en  = 1'b1;
          wr_a   = kidx_r;
          wr_d   = kfill_row;
          st_nxt = ST_OUT;
        end else if (kcnt_r == KICK_W'(KICKS)) begin
          st_nxt = ST_STASH;
        end else begin
          rd_en  = 1'b1;
          rd_a   = kidx_r;
          st_nxt = ST_KWAIT;
        end
      end
      ST_STASH: begin
        st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_CLEAR;
      clr_r    <= '0;
      sfill_r  <= '0;
      count_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      case (st_r)
        ST_CHK: begin
          if (!cmd_r.insert) begin
            ovalid_r <= 1'b1;
          end else if (!(stash_hit || hit1 || hit2) && (e1 || e2)) begin
            count_r  <= count_r + 1'b1;
            ovalid_r <= 1'b1;
          end else if (stash_hit || hit1 || hit2) begin
            ovalid_r <= 1'b1;
          end
        end
        ST_KCHK: begin
          if (ke) begin
            count_r  <= count_r + 1'b1;
            ovalid_r <= 1'b1;
          end
        end
        ST_STASH: begin
          ovalid_r <= 1'b1;
          if (sfill_r < 2'd2) begin
            sfill_r <= sfill_r + 1'b1;
            count_r <= count_r + 1'b1;
          end
        end
        ST_OUT: begin
          if (out_tready) begin
            ovalid_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stag_r[0] <= '0;
      stag_r[1] <= '0;
      sbkt_r[0] <= '0;
      sbkt_r[1] <= '0;
    end else if (st_r == ST_STASH && sfill_r < 2'd2) begin
      stag_r[sfill_r[0]] <= ktag_r;
      sbkt_r[sfill_r[0]] <= (vb < va) ? vb : va;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        cmd_r <= q_cmd;
        i1_r  <= ci1;
        i2_r  <= ci2;
      end
      ST_RD1: row1_r <= rd_q;
      ST_CHK: begin
        ktag_r <= cmd_r.tag;
        kidx_r <= i1_r;
        kcnt_r <= '0;
        if (!cmd_r.insert) begin
          oc_r <= (stash_hit || hit1 || hit2) ? OC_HIT : OC_MISS;
        end else if (stash_hit || hit1 || hit2) begin
          oc_r <= OC_PRESENT;
        end else begin
          oc_r <= OC_PLACED;
        end
      end
      ST_KWAIT: begin
        ktag_r <= kout;
        kidx_r <= knext;
        kcnt_r <= kcnt_r + 1'b1;
      end
      ST_KCHK: oc_r <= OC_PLACED;
      ST_STASH: oc_r <= (sfill_r < 2'd2) ? OC_STASHED : OC_DROPPED;
      default: ;
    endcase
  end

  assign out_tvalid    = ovalid_r && st_r == ST_OUT;
  assign out_outcome   = oc_r;
  assign out_occupancy = (count_r > CTR_W'(CNT_MAX)) ? COUNT_W'(CNT_MAX)
                                                     : count_r[COUNT_W-1:0];

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");
  a_stash: assert property (@(posedge clk) disable iff (!rst_n) sfill_r <= 2'd2)
    else $error("stash overfilled");
  a_kicks: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_KCHK |-> kcnt_r <= KICK_W'(KICKS)) else $error("kick bound");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_outcome))
    else $error("result dropped");

endmodule

### design/cuckoo_fingerprint_set_unit.sv
// ----------------------------------------------------------------------------
// Cuckoo fingerprint set unit
// Cuckoo filter of 32-bit tags with a two-entry stash.
// ----------------------------------------------------------------------------
// Input beats carry a 64-bit fingerprint in in_tdata and the command in
// in_tuser (0 lookup, 1 insert). Each beat yields one result beat with the
// outcome and the occupancy of table and stash.
// A front end derives the tag and queues up to two commands; the back end
// runs one command at a time against a bucket memory with one write and one
// read port. A lookup or a simple insert reads both buckets and decides in
// CHK; the back end takes a new command only in IDLE, once the last result
// is taken. An insert that kicks runs KWAIT, KRD and KCHK per move, up to
// 2*LOG_BUCKETS+1 moves, then STASH when the victim goes to the stash or is
// dropped. After reset, a clearing pass over all 2^LOG_BUCKETS buckets
// empties the memory; the front queue still takes two beats meanwhile.
// When the receiver stalls, the result is held and the back end waits.
// ----------------------------------------------------------------------------
module cuckoo_fingerprint_set_unit #(
  parameter int unsigned LOG_BUCKETS  = 10,
  parameter int unsigned BUCKET_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // fingerprint[63:0]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // outcome[2:0], occupancy[15:3]
);
  import cfs_pkg::*;

  logic     q_valid, q_ready;
  cmd_t     q_cmd;
  logic [OUTCOME_W-1:0] oc;
  logic [COUNT_W-1:0]   occ;

  cfs_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_data(in_tdata), .in_cmd(in_tuser),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  cfs_back #(.LOG_BUCKETS(LOG_BUCKETS), .BUCKET_SLOTS(BUCKET_SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_outcome(oc), .out_occupancy(occ)
  );

  assign out_tdata = {occ, oc};

endmodule

### tb/sv/cuckoo_fingerprint_set_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cuckoo fingerprint set unit testbench
// Drives lookup and insert beats with random gaps on both sides and checks
// every result beat against a behavioral copy of the tag table and stash.
// ----------------------------------------------------------------------------
module cuckoo_fingerprint_set_unit_tb;
  import cfs_pkg::*;

  localparam int LOGB   = 10;
  localparam int SLOTS  = 4;
  localparam int NB     = 1 << LOGB;
  localparam int BMASK  = NB - 1;
  localparam int KICKS  = 2 * LOGB + 1;
  localparam int N_RAND = 700;

  typedef struct packed {
    logic            insert;
    logic [63:0]     fp;
    logic            has_exp;
    outcome_t        oc;
    logic [12:0]     occ;
  } row_t;

  typedef struct packed {
    outcome_t    oc;
    logic [12:0] occ;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;

  cuckoo_fingerprint_set_unit #(.LOG_BUCKETS(LOGB), .BUCKET_SLOTS(SLOTS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #4 clk = ~clk;

  // Predictor state.
  logic [31:0] tbl [NB*SLOTS];
  logic [31:0] st_tag [2];
  int unsigned st_bkt [2];
  int unsigned st_fill;
  int unsigned n_tags;

  res_t  pending [$];
  row_t  dir_rows [$];
  int    errors = 0;
  int    n_checked = 0;
  int    oc_seen [6];
  logic  quiet = 1'b0;
  logic  [63:0] inserted_fps [$];

  function automatic logic [31:0] tag_of(logic [63:0] fp);
    logic [31:0] lo, hi;
    logic [32:0] s;
    lo = fp[31:0] + 32'd1;
    if (lo == 0) lo = 32'd1;
    hi = fp[63:32];
    s = {1'b0, lo} + {1'b0, hi};
    return s[31:0] + {31'd0, s[32]};
  endfunction

  function automatic bit bucket_has(int unsigned b, logic [31:0] t);
    for (int s = 0; s < SLOTS; s++) if (tbl[b*SLOTS+s] == t) return 1;
    return 0;
  endfunction

  function automatic bit is_held(logic [31:0] t, int unsigned i1, int unsigned i2);
    for (int k = 0; k < st_fill; k++)
      if (st_tag[k] == t && (st_bkt[k] == i1 || st_bkt[k] == i2)) return 1;
    return bucket_has(i1, t) || bucket_has(i2, t);
  endfunction

  function automatic bit place_in(int unsigned b, logic [31:0] t);
    for (int s = 0; s < SLOTS; s++)
      if (tbl[b*SLOTS+s] == 0) begin
        tbl[b*SLOTS+s] = t;
        return 1;
      end
    return 0;
  endfunction

  function automatic res_t set_step(logic insert, logic [63:0] fp);
    logic [31:0] t, victim, outt;
    int unsigned i1, i2, tmp, idx, a, b;
    bit done;
    res_t r;
    t = tag_of(fp);
    i1 = fp[31:0] & BMASK;
    i2 = (fp[31:0] ^ t) & BMASK;
    if (st_fill != 0 && i1 > i2) begin
      tmp = i1; i1 = i2; i2 = tmp;
    end
    done = 0;
    if (!insert) begin
      r.oc = is_held(t, i1, i2) ? OC_HIT : OC_MISS;
    end else if (is_held(t, i1, i2)) begin
      r.oc = OC_PRESENT;
    end else begin
      for (int s = 0; s < SLOTS && !done; s++) begin
        if (tbl[i1*SLOTS+s] == 0) begin
          tbl[i1*SLOTS+s] = t; done = 1;
        end else if (tbl[i2*SLOTS+s] == 0) begin
          tbl[i2*SLOTS+s] = t; done = 1;
        end
      end
      // Both buckets full: shift the bucket along and push the oldest tag onward.
      victim = t;
      idx = i1;
      for (int n = 0; n < KICKS && !done; n++) begin
        outt = tbl[idx*SLOTS];
        for (int s = 0; s + 1 < SLOTS; s++) tbl[idx*SLOTS+s] = tbl[idx*SLOTS+s+1];
        tbl[idx*SLOTS+SLOTS-1] = victim;
        victim = outt;
        idx = (idx ^ victim) & BMASK;
        if (place_in(idx, victim)) done = 1;
      end
      if (done) begin
        n_tags++;
        r.oc = OC_PLACED;
      end else if (st_fill < 2) begin
        a = idx & BMASK;
        b = (idx ^ victim) & BMASK;
        st_tag[st_fill] = victim;
        st_bkt[st_fill] = (b < a) ? b : a;
        st_fill++;
        n_tags++;
        r.oc = OC_STASHED;
      end else begin
        r.oc = OC_DROPPED;
      end
    end
    r.occ = (n_tags > 8191) ? 13'd8191 : n_tags[12:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch %0d: %s got %0d expected %0d", n_checked, what, got, want);
  endtask

  // Sends one beat; the predicted result is queued on acceptance and, if has_exp, checked against the typed one.
  task automatic send_beat(logic insert, logic [63:0] fp, bit has_exp, res_t typed);
    res_t p;
    while (!quiet && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= fp;
    in_tuser  <= insert;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = set_step(insert, fp);
    if (insert) inserted_fps.push_back(fp);
    if (has_exp && p != typed) report_mismatch("directed row", p, typed);
    pending.push_back(p);
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending.size() == 0) begin
          report_mismatch("unexpected beat outcome", out_tdata[2:0], -1);
        end else begin
          e = pending.pop_front();
          if (out_tdata[2:0] != e.oc) report_mismatch("outcome", out_tdata[2:0], e.oc);
          if (out_tdata[15:3] != e.occ) report_mismatch("occupancy", out_tdata[15:3], e.occ);
          if (e.oc <= OC_DROPPED) oc_seen[e.oc]++;
        end
        n_checked++;
      end
      out_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 35);
    end
  end

  // A fingerprint whose two buckets are bkt and bkt ^ 3: the low bits are
  // fixed and the high half is chosen so that the tag's low bits come out as 3.
  function automatic logic [63:0] crowd_fp(int unsigned bkt);
    logic [31:0] lo, hi, t;
    logic [63:0] fp;
    do begin
      lo = ($urandom() & ~32'(BMASK)) | 32'(bkt);
      t  = ($urandom() & ~32'(BMASK)) | 32'd3;
      hi = t - lo - 32'd1;
      fp = {hi, lo};
      t  = tag_of(fp);
    end while (t[LOGB-1:0] != LOGB'(3));
    return fp;
  endfunction

  initial begin
    res_t nr;
    row_t rw;
    logic [63:0] fp;
    int k;
    for (int i = 0; i < NB*SLOTS; i++) tbl[i] = '0;
    st_tag[0] = 0; st_tag[1] = 0; st_bkt[0] = 0; st_bkt[1] = 0;
    st_fill = 0; n_tags = 0;
    for (int i = 0; i < 6; i++) oc_seen[i] = 0;

    // Directed rows: fields at their extremes, a lookup miss on an empty
    // table, a duplicate insert, and a crowded bucket pair forcing the kick
    // loop, the stash and finally a dropped victim.
    dir_rows.push_back('{1'b0, 64'h0, 1'b1, OC_MISS, 13'd0});
    dir_rows.push_back('{1'b1, 64'h0, 1'b1, OC_PLACED, 13'd1});
    dir_rows.push_back('{1'b0, 64'h0, 1'b1, OC_HIT, 13'd1});
    dir_rows.push_back('{1'b1, 64'h0, 1'b1, OC_PRESENT, 13'd1});
    dir_rows.push_back('{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, OC_MISS, 13'd0});
    dir_rows.push_back('{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, OC_MISS, 13'd0});
    dir_rows.push_back('{1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0, OC_MISS, 13'd0});
    dir_rows.push_back('{1'b1, 64'hFFFF_FFFF_0000_0000, 1'b0, OC_MISS, 13'd0});
    dir_rows.push_back('{1'b1, 64'h8000_0000_7FFF_FFFE, 1'b0, OC_MISS, 13'd0});
    // Tags that make both indices equal (tag low bits zero).
    dir_rows.push_back('{1'b1, 64'h0000_0000_0000_03FF, 1'b0, OC_MISS, 13'd0});
    dir_rows.push_back('{1'b0, 64'h0000_0000_0000_03FF, 1'b0, OC_MISS, 13'd0});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      rw = dir_rows[i];
      nr.oc = rw.oc; nr.occ = rw.occ;
      send_beat(rw.insert, rw.fp, rw.has_exp, nr);
    end
    // Crowd two buckets so the kick loop, stash and drop all occur.
    for (int i = 0; i < 14; i++) send_beat(1'b1, crowd_fp(5), 1'b0, nr);

    // Random part; a quiet stretch in the middle with no idling.
    for (int i = 0; i < N_RAND; i++) begin
      quiet = (i >= 300 && i < 400);
      k = $urandom_range(99);
      if (k < 40) begin
        fp = {32'($urandom()), 32'($urandom())};
        send_beat(1'b1, fp, 1'b0, nr);
      end else if (k < 55 && inserted_fps.size() > 0) begin
        fp = inserted_fps[$urandom_range(inserted_fps.size() - 1)];
        send_beat($urandom_range(1), fp, 1'b0, nr);
      end else if (k < 70) begin
        send_beat(1'b1, crowd_fp($urandom_range(7)), 1'b0, nr);
      end else begin
        fp = {32'($urandom()), 32'($urandom())};
        send_beat(1'b0, fp, 1'b0, nr);
      end
    end
    quiet = 1'b0;
    in_tvalid <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("checked %0d result beats: miss %0d hit %0d present %0d", n_checked,
             oc_seen[0], oc_seen[1], oc_seen[2]);
    $display("placed %0d stashed %0d dropped %0d", oc_seen[3], oc_seen[4], oc_seen[5]);
    if (errors == 0 && pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule

### cuckoo_fingerprint_set_unit.f
design/cfs_pkg.sv
design/cfs_front.sv
design/cfs_back.sv
design/cuckoo_fingerprint_set_unit.sv
tb/sv/cuckoo_fingerprint_set_unit_tb.sv
